### rtl/edd_pkg.sv
`timescale 1ns / 1ps

package edd_pkg;

   localparam int COLOUR_BITS = 8;
   localparam int LANES       = 3;
   localparam int PIXEL_BITS  = 4 * COLOUR_BITS;
   localparam int CFG_BITS    = 12;
   localparam int WIDTH_RESET = 640;

   localparam int MAX_WIDTH = 2048;
   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int CMP_BITS  = (CFG_BITS > ADDR_BITS + 1) ? CFG_BITS : ADDR_BITS + 1;

   localparam int FRAC_BITS = 8;
   localparam int ERR_BITS  = FRAC_BITS + 10;
   localparam int SUM_BITS  = ERR_BITS + 2;
   localparam int PROD_BITS = SUM_BITS + 3;
   localparam int GQ_BITS   = 2 * COLOUR_BITS;
   localparam int GRAY_BITS = FRAC_BITS + COLOUR_BITS;

   localparam int DIV_STEPS    = COLOUR_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   typedef logic [COLOUR_BITS-1:0]        colour_type;
   typedef colour_type [LANES-1:0]        lanes_type;
   typedef logic [PIXEL_BITS-1:0]         pixel_type;
   typedef logic [CFG_BITS-1:0]           cfg_type;
   typedef logic [CMP_BITS-1:0]           cmp_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic signed [ERR_BITS-1:0]    err_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic [GQ_BITS-1:0]            gq_type;
   typedef logic [GRAY_BITS-1:0]          gray_type;
   typedef logic [DIV_CNT_BITS-1:0]       div_cnt_type;
   typedef logic [2:0]                    share_type;

   localparam colour_type WEIGHT_RED   = 8'd77;
   localparam colour_type WEIGHT_GREEN = 8'd151;
   localparam colour_type WEIGHT_BLUE  = 8'd28;

   localparam share_type SHARE_AHEAD  = 3'd7;
   localparam share_type SHARE_BEHIND = 3'd3;
   localparam share_type SHARE_BELOW  = 3'd5;
   localparam share_type SHARE_DIAG   = 3'd1;

   localparam sum_type HALF_LEVEL = sum_type'(255 << (FRAC_BITS - 1));
   localparam sum_type FULL_LEVEL = sum_type'(255 << FRAC_BITS);

   localparam colour_type LEVEL_DARK   = 8'h00;
   localparam colour_type LEVEL_BRIGHT = 8'hFF;

   localparam prod_type ERR_MAX = prod_type'((1 << (ERR_BITS - 1)) - 1);
   localparam prod_type ERR_MIN = ~ERR_MAX;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic div_start;
      logic gray_calc;
      logic err_calc;
      logic write_x;
      logic write_bx;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic clear_last;
      logic slot_free;
   } status_type;

   // weighted sum carries 8 fraction bits, rescale to the working format
   function automatic gray_type scale_gray(input gq_type g);
      logic [GQ_BITS+GRAY_BITS-1:0] wide;
      wide = {{GRAY_BITS{1'b0}}, g};
      if (FRAC_BITS >= COLOUR_BITS) begin
         wide = wide << (FRAC_BITS - COLOUR_BITS);
      end else begin
         wide = wide >> (COLOUR_BITS - FRAC_BITS);
      end
      return wide[GRAY_BITS-1:0];
   endfunction

   // floor(err * k / 16)
   function automatic prod_type share16(input sum_type err, input share_type k);
      prod_type e;
      prod_type m;
      prod_type p;
      e = prod_type'(err);
      m = prod_type'({1'b0, k});
      p = e * m;
      return p >>> 4;
   endfunction

   function automatic err_type sat_err(input prod_type v);
      if (v > ERR_MAX) begin
         return err_type'(ERR_MAX);
      end else if (v < ERR_MIN) begin
         return err_type'(ERR_MIN);
      end
      return v[ERR_BITS-1:0];
   endfunction

endpackage

### rtl/error_diffusion_dither_unit.sv
`timescale 1ns / 1ps

// Serpentine error-diffusion dither: one premultiplied RGBA pixel in, one
// black or white level out.
// req_*: pixel transfers, rows alternately left to right and right to left;
//    req_tuser marks the first pixel of a frame.
// rsp_*: level in rsp_tdata, rsp_tlast set on the last pixel of each row.
// csr_*: image width in pixels, always ready; write only between pixels.
// One pixel is worked on at a time: the next is taken only once the result of
// the last has been loaded into the output register. The work per pixel is the
// eight-step un-premultiply divider (three colour lanes in parallel) and the two
// read-modify-write passes on the single write port of the row error store.
// A frame-start pixel first sweeps the 2048-entry row store to zero.
// After reset the same sweep runs with req_tready low.
// If the receiver stalls, the result is held in the output register; the
// next pixel is still taken and processed, and its result waits until the
// register has been emptied.
module error_diffusion_dither_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [edd_pkg::PIXEL_BITS-1:0]  req_tdata,  // red, green, blue, alpha
   input  logic                       req_tuser,           // first_of_frame
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [edd_pkg::COLOUR_BITS-1:0] rsp_tdata,  // level
   output logic                       rsp_tlast,           // end_of_row
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [edd_pkg::CFG_BITS-1:0]    csr_data    // image_width
);

   edd_pkg::cmd_type    cmd;
   edd_pkg::status_type status;

   assign csr_ready = 1'b1;

   edd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_first (req_tuser),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   edd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .pixel          (req_tdata),
      .first_of_frame (req_tuser),
      .width_write    (csr_valid & csr_ready),
      .width_value    (csr_data),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_level      (rsp_tdata),
      .rsp_end_of_row (rsp_tlast)
   );

endmodule

### rtl/edd_ram.sv
`timescale 1ns / 1ps

module edd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/edd_divider.sv
`timescale 1ns / 1ps

module edd_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  edd_pkg::lanes_type  colour,
   input  edd_pkg::colour_type alpha,
   output edd_pkg::lanes_type  quotient,
   output logic                busy
);

   // three restoring dividers side by side, one quotient bit per cycle
   edd_pkg::lanes_type   rem_ff, rem_in;
   edd_pkg::lanes_type   num_ff, num_in;
   edd_pkg::lanes_type   q_ff, q_in;
   logic [edd_pkg::LANES-1:0] sat_ff, sat_in;
   edd_pkg::colour_type  divisor_ff, divisor_in;
   logic                 busy_ff, busy_in;
   edd_pkg::div_cnt_type cnt_ff, cnt_in;

   always_comb begin
      edd_pkg::gq_type                  scaled;
      logic [edd_pkg::COLOUR_BITS:0]    trial;
      scaled     = '0;
      trial      = '0;
      rem_in     = rem_ff;
      num_in     = num_ff;
      q_in       = q_ff;
      sat_in     = sat_ff;
      divisor_in = divisor_ff;
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      if (start) begin
         divisor_in = alpha;
         busy_in    = 1'b1;
         cnt_in     = '0;
         for (int l = 0; l < edd_pkg::LANES; l++) begin
            // c * 255 as (c << 8) - c
            scaled = {colour[l], edd_pkg::colour_type'(0)} -
                     {edd_pkg::colour_type'(0), colour[l]};
            // quotient would exceed 255 exactly when the high byte reaches alpha
            sat_in[l] = scaled[edd_pkg::GQ_BITS-1 -: edd_pkg::COLOUR_BITS] >= alpha;
            rem_in[l] = scaled[edd_pkg::GQ_BITS-1 -: edd_pkg::COLOUR_BITS];
            num_in[l] = scaled[edd_pkg::COLOUR_BITS-1:0];
            q_in[l]   = '0;
         end
      end else if (busy_ff) begin
         for (int l = 0; l < edd_pkg::LANES; l++) begin
            trial = {rem_ff[l], num_ff[l][edd_pkg::COLOUR_BITS-1]};
            if (trial >= {1'b0, divisor_ff}) begin
               rem_in[l] = edd_pkg::colour_type'(trial - {1'b0, divisor_ff});
               q_in[l]   = {q_ff[l][edd_pkg::COLOUR_BITS-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[edd_pkg::COLOUR_BITS-1:0];
               q_in[l]   = {q_ff[l][edd_pkg::COLOUR_BITS-2:0], 1'b0};
            end
            num_in[l] = {num_ff[l][edd_pkg::COLOUR_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + edd_pkg::div_cnt_type'(1);
         if (cnt_ff == edd_pkg::div_cnt_type'(edd_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      q_ff       <= q_in;
      sat_ff     <= sat_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      for (int l = 0; l < edd_pkg::LANES; l++) begin
         if (divisor_ff == '0) begin
            quotient[l] = '0;
         end else if (sat_ff[l]) begin
            quotient[l] = '1;
         end else begin
            quotient[l] = q_ff[l];
         end
      end
   end

   assign busy = busy_ff;

endmodule

### rtl/edd_datapath.sv
`timescale 1ns / 1ps

module edd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  edd_pkg::cmd_type     cmd,
   output edd_pkg::status_type  status,
   input  edd_pkg::pixel_type   pixel,
   input  logic                 first_of_frame,
   input  logic                 width_write,
   input  edd_pkg::cfg_type     width_value,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output edd_pkg::colour_type  rsp_level,
   output logic                 rsp_end_of_row
);

   edd_pkg::cfg_type    width_ff, width_in;
   edd_pkg::addr_type   col_ff, col_in;
   logic                dir_ff, dir_in;
   edd_pkg::err_type    ahead_ff, ahead_in;
   edd_pkg::err_type    diag_ff, diag_in;
   edd_pkg::addr_type   clr_addr_ff, clr_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;

   edd_pkg::pixel_type  pix_ff, pix_in;
   edd_pkg::addr_type   x_ff, x_in;
   edd_pkg::addr_type   bx_ff, bx_in;
   edd_pkg::addr_type   colc_ff, colc_in;
   logic                last_ff, last_in;
   logic                colnz_ff, colnz_in;
   edd_pkg::gray_type   gray_ff, gray_in;
   edd_pkg::sum_type    err_ff, err_in;
   logic                bright_ff, bright_in;
   edd_pkg::colour_type level_ff, level_in;
   logic                eor_ff, eor_in;

   edd_pkg::cmp_type    width_less;
   edd_pkg::addr_type   last_col;
   edd_pkg::addr_type   colc_now;
   edd_pkg::addr_type   x_now;
   edd_pkg::addr_type   bx_now;
   edd_pkg::lanes_type  quotient;
   logic                div_busy;
   edd_pkg::gq_type     gq;
   edd_pkg::sum_type    v_sum;
   edd_pkg::err_type    below_rd;
   edd_pkg::err_type    below_x_val;
   edd_pkg::err_type    below_bx_val;

   logic                wr_en;
   edd_pkg::addr_type   wr_addr;
   edd_pkg::err_type    wr_data;
   logic                rd_en;
   edd_pkg::addr_type   rd_addr;

   edd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .colour   (edd_pkg::lanes_type'(pix_ff[edd_pkg::LANES*edd_pkg::COLOUR_BITS-1:0])),
      .alpha    (pix_ff[edd_pkg::PIXEL_BITS-1 -: edd_pkg::COLOUR_BITS]),
      .quotient (quotient),
      .busy     (div_busy)
   );

   edd_ram #(
      .WIDTH (edd_pkg::ERR_BITS),
      .DEPTH (edd_pkg::MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (below_rd)
   );

   // width of zero counts as one, oversize widths clamp to the store depth
   assign width_less = edd_pkg::cmp_type'(width_ff) - edd_pkg::cmp_type'(1);

   always_comb begin
      if (width_ff == '0) begin
         last_col = '0;
      end else if (edd_pkg::cmp_type'(width_ff) > edd_pkg::cmp_type'(edd_pkg::MAX_WIDTH)) begin
         last_col = edd_pkg::addr_type'(edd_pkg::MAX_WIDTH - 1);
      end else begin
         last_col = width_less[edd_pkg::ADDR_BITS-1:0];
      end
   end

   // a width shrunk mid-row pulls the column back onto the last one
   assign colc_now = (col_ff > last_col) ? last_col : col_ff;
   assign x_now    = dir_ff ? (last_col - colc_now) : colc_now;
   assign bx_now   = dir_ff ? (x_now + edd_pkg::addr_type'(1))
                            : (x_now - edd_pkg::addr_type'(1));

   assign gq = edd_pkg::gq_type'(quotient[0]) * edd_pkg::gq_type'(edd_pkg::WEIGHT_RED)
             + edd_pkg::gq_type'(quotient[1]) * edd_pkg::gq_type'(edd_pkg::WEIGHT_GREEN)
             + edd_pkg::gq_type'(quotient[2]) * edd_pkg::gq_type'(edd_pkg::WEIGHT_BLUE);

   assign v_sum = edd_pkg::sum_type'(gray_ff) + edd_pkg::sum_type'(ahead_ff)
                + edd_pkg::sum_type'(below_rd);

   assign below_x_val = edd_pkg::sat_err(edd_pkg::share16(err_ff, edd_pkg::SHARE_BELOW)
                                         + edd_pkg::prod_type'(diag_ff));
   assign below_bx_val = edd_pkg::sat_err(edd_pkg::prod_type'(below_rd)
                                          + edd_pkg::share16(err_ff, edd_pkg::SHARE_BEHIND));

   // row store ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = x_ff;
      wr_data = below_x_val;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (cmd.write_x) begin
         wr_en   = 1'b1;
         wr_addr = x_ff;
         wr_data = below_x_val;
      end else if (cmd.write_bx) begin
         wr_en   = colnz_ff;
         wr_addr = bx_ff;
         wr_data = below_bx_val;
      end
   end

   assign rd_en   = cmd.div_start | cmd.err_calc;
   assign rd_addr = cmd.div_start ? x_now : bx_ff;

   always_comb begin
      width_in     = width_ff;
      col_in       = col_ff;
      dir_in       = dir_ff;
      ahead_in     = ahead_ff;
      diag_in      = diag_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      pix_in       = pix_ff;
      x_in         = x_ff;
      bx_in        = bx_ff;
      colc_in      = colc_ff;
      last_in      = last_ff;
      colnz_in     = colnz_ff;
      gray_in      = gray_ff;
      err_in       = err_ff;
      bright_in    = bright_ff;
      level_in     = level_ff;
      eor_in       = eor_ff;

      if (width_write) begin
         width_in = width_value;
      end

      if (cmd.accept) begin
         pix_in = pixel;
         if (first_of_frame) begin
            col_in   = '0;
            dir_in   = 1'b0;
            ahead_in = '0;
            diag_in  = '0;
         end
      end

      if (cmd.clear_step) begin
         if (status.clear_last) begin
            clr_addr_in = '0;
         end else begin
            clr_addr_in = clr_addr_ff + edd_pkg::addr_type'(1);
         end
      end

      if (cmd.div_start) begin
         x_in     = x_now;
         bx_in    = bx_now;
         colc_in  = colc_now;
         last_in  = (colc_now == last_col);
         colnz_in = (colc_now != '0);
      end

      if (cmd.gray_calc) begin
         gray_in = edd_pkg::scale_gray(gq);
      end

      if (cmd.err_calc) begin
         bright_in = (v_sum >= edd_pkg::HALF_LEVEL);
         err_in    = (v_sum >= edd_pkg::HALF_LEVEL) ? (v_sum - edd_pkg::FULL_LEVEL) : v_sum;
      end

      if (cmd.write_bx) begin
         if (last_ff) begin
            ahead_in = '0;
            diag_in  = '0;
            col_in   = '0;
            dir_in   = ~dir_ff;
         end else begin
            ahead_in = edd_pkg::sat_err(edd_pkg::share16(err_ff, edd_pkg::SHARE_AHEAD));
            diag_in  = edd_pkg::sat_err(edd_pkg::share16(err_ff, edd_pkg::SHARE_DIAG));
            col_in   = colc_ff + edd_pkg::addr_type'(1);
         end
      end

      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
         level_in     = bright_ff ? edd_pkg::LEVEL_BRIGHT : edd_pkg::LEVEL_DARK;
         eor_in       = last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= edd_pkg::cfg_type'(edd_pkg::WIDTH_RESET);
         col_ff       <= '0;
         dir_ff       <= 1'b0;
         ahead_ff     <= '0;
         diag_ff      <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         col_ff       <= col_in;
         dir_ff       <= dir_in;
         ahead_ff     <= ahead_in;
         diag_ff      <= diag_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff    <= pix_in;
      x_ff      <= x_in;
      bx_ff     <= bx_in;
      colc_ff   <= colc_in;
      last_ff   <= last_in;
      colnz_ff  <= colnz_in;
      gray_ff   <= gray_in;
      err_ff    <= err_in;
      bright_ff <= bright_in;
      level_ff  <= level_in;
      eor_ff    <= eor_in;
   end

   assign status.div_busy   = div_busy;
   assign status.clear_last = (clr_addr_ff == edd_pkg::addr_type'(edd_pkg::MAX_WIDTH - 1));
   assign status.slot_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level      = level_ff;
   assign rsp_end_of_row = eor_ff;

endmodule

### rtl/edd_ctrl.sv
`timescale 1ns / 1ps

module edd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_first,
   input  edd_pkg::status_type status,
   output logic                req_ready,
   output edd_pkg::cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_CLEAR_RESET = 10'b00_0000_0001,
      ST_IDLE        = 10'b00_0000_0010,
      ST_CLEAR_FRAME = 10'b00_0000_0100,
      ST_DIV_LOAD    = 10'b00_0000_1000,
      ST_DIV_RUN     = 10'b00_0001_0000,
      ST_GRAY        = 10'b00_0010_0000,
      ST_ERROR       = 10'b00_0100_0000,
      ST_WRITE_X     = 10'b00_1000_0000,
      ST_WRITE_BX    = 10'b01_0000_0000,
      ST_RESULT      = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR_RESET: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = req_first ? ST_CLEAR_FRAME : ST_DIV_LOAD;
            end
         end
         ST_CLEAR_FRAME: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (!status.div_busy) begin
               state_in = ST_GRAY;
            end
         end
         ST_GRAY: begin
            cmd.gray_calc = 1'b1;
            state_in      = ST_ERROR;
         end
         ST_ERROR: begin
            cmd.err_calc = 1'b1;
            state_in     = ST_WRITE_X;
         end
         ST_WRITE_X: begin
            cmd.write_x = 1'b1;
            state_in    = ST_WRITE_BX;
         end
         ST_WRITE_BX: begin
            cmd.write_bx = 1'b1;
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            // wait for the output register to drain
            if (status.slot_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR_RESET;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/edd_checker.sv
`timescale 1ns / 1ps

module edd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [edd_pkg::COLOUR_BITS-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_level_binary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == edd_pkg::LEVEL_DARK) || (rsp_tdata == edd_pkg::LEVEL_BRIGHT))
      else $error("level is neither black nor white");

   // one pixel in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("pixel taken while another is in flight");

   // a fresh result only comes out of a busy block
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without a pixel in flight");

endmodule

bind error_diffusion_dither_unit edd_checker u_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int QUIET_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 20;
   localparam int TARGET_ITEMS = 1250;
   localparam int HALF_GRAY    = 255 << (edd_pkg::FRAC_BITS - 1);
   localparam int FULL_GRAY    = 255 << edd_pkg::FRAC_BITS;
   localparam int ERR_HI       = (1 << (edd_pkg::ERR_BITS - 1)) - 1;
   localparam int ERR_LO       = -ERR_HI - 1;

   typedef struct {
      edd_pkg::colour_type red;
      edd_pkg::colour_type green;
      edd_pkg::colour_type blue;
      edd_pkg::colour_type alpha;
      logic                first;
   } pixel_item_type;

   typedef struct {
      edd_pkg::colour_type level;
      logic                end_of_row;
   } dither_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [edd_pkg::PIXEL_BITS-1:0]  req_tdata = '0;   // red, green, blue, alpha
   logic                  req_tuser = 1'b0; // first_of_frame
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [edd_pkg::COLOUR_BITS-1:0] rsp_tdata;       // level
   logic                  rsp_tlast;        // end_of_row
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [edd_pkg::CFG_BITS-1:0]    csr_data = '0;    // image_width

   error_diffusion_dither_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   edd_pkg::cfg_type width_reg;
   int          below_row [edd_pkg::MAX_WIDTH];
   int          ahead_err;
   int          diag_err;
   int unsigned col_count;
   bit          reverse_dir;

   pixel_item_type    pending_pixels [$];
   dither_result_type expected_levels [$];
   pixel_item_type    cur_pixel;
   dither_result_type want_result;

   int  pixels_pushed   = 0;
   int  pixels_accepted = 0;
   int  results_seen    = 0;
   int  error_count     = 0;
   int  quiet_cycles    = 0;
   int  send_gap        = 0;
   int  stall_left      = 0;
   int  hold_left       = 0;
   bit  sent_now        = 1'b0;
   bit  hold_request    = 1'b0;
   bit  sender_idle_on  = 1'b1;
   bit  receiver_idle_on = 1'b1;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic int clip_err(input int v);
      if (v > ERR_HI) return ERR_HI;
      if (v < ERR_LO) return ERR_LO;
      return v;
   endfunction

   // floor(e * k / 16)
   function automatic int err_share(input int e, input int k);
      int p;
      p = e * k;
      return p >>> 4;
   endfunction

   function automatic int unsigned restore_colour(input edd_pkg::colour_type c,
                                                  input edd_pkg::colour_type a);
      int unsigned q;
      if (a == 0) return 0;
      q = (int'(c) * 255) / int'(a);
      return (q > 255) ? 255 : q;
   endfunction

   task automatic clear_error_state();
      foreach (below_row[i]) below_row[i] = 0;
      ahead_err   = 0;
      diag_err    = 0;
      col_count   = 0;
      reverse_dir = 1'b0;
   endtask

   task automatic predict_pixel(input pixel_item_type p);
      int unsigned       r, g, b, w, col, x, bx, gray;
      int                v, e;
      bit                bright, last;
      dither_result_type res;
      r = restore_colour(p.red, p.alpha);
      g = restore_colour(p.green, p.alpha);
      b = restore_colour(p.blue, p.alpha);
      if (p.first) clear_error_state();
      w = width_reg;
      if (w == 0) w = 1;
      if (w > edd_pkg::MAX_WIDTH) w = edd_pkg::MAX_WIDTH;
      col = col_count;
      if (col > w - 1) col = w - 1;
      x    = reverse_dir ? (w - 1 - col) : col;
      last = (col == w - 1);
      gray = (77 * r + 151 * g + 28 * b) << (edd_pkg::FRAC_BITS - 8);
      v      = int'(gray) + ahead_err + below_row[x];
      bright = (v >= HALF_GRAY);
      e      = v - (bright ? FULL_GRAY : 0);
      below_row[x] = clip_err(err_share(e, 5) + diag_err);
      if (col > 0) begin
         bx = reverse_dir ? x + 1 : x - 1;
         if (bx < edd_pkg::MAX_WIDTH) below_row[bx] = clip_err(below_row[bx] + err_share(e, 3));
      end
      if (last) begin
         ahead_err   = 0;
         diag_err    = 0;
         col_count   = 0;
         reverse_dir = !reverse_dir;
      end else begin
         ahead_err = clip_err(err_share(e, 7));
         diag_err  = clip_err(err_share(e, 1));
         col_count = col + 1;
      end
      res.level      = bright ? edd_pkg::LEVEL_BRIGHT : edd_pkg::LEVEL_DARK;
      res.end_of_row = last;
      expected_levels.push_back(res);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
      error_count++;
   endtask

   task automatic push_pixel(input int r, input int g, input int b, input int a,
                             input bit first);
      pixel_item_type p;
      p.red   = r[7:0];
      p.green = g[7:0];
      p.blue  = b[7:0];
      p.alpha = a[7:0];
      p.first = first;
      pending_pixels.push_back(p);
      pixels_pushed++;
   endtask

   task automatic write_width(input int unsigned w);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= w[edd_pkg::CFG_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      width_reg = w[edd_pkg::CFG_BITS-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // every transfer accepted and every result back, then let the pipeline settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pixels_accepted != pixels_pushed || expected_levels.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // pixel driver
   always @(posedge clock) begin
      sent_now = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         predict_pixel(cur_pixel);
         pixels_accepted++;
         sent_now = 1'b1;
      end
      @(negedge clock);
      if (sent_now || !req_tvalid) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            cur_pixel = pending_pixels.pop_front();
            req_tdata  <= {cur_pixel.alpha, cur_pixel.blue, cur_pixel.green, cur_pixel.red};
            req_tuser  <= cur_pixel.first;
            req_tvalid <= 1'b1;
            send_gap = sender_idle_on ? pick_gap() : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch("result with nothing pending, level", rsp_tdata, 0);
         end else begin
            want_result = expected_levels.pop_front();
            if (rsp_tdata !== want_result.level)
               report_mismatch("level", rsp_tdata, want_result.level);
            if (rsp_tlast !== want_result.end_of_row)
               report_mismatch("end_of_row", rsp_tlast, want_result.end_of_row);
         end
         results_seen++;
      end
      @(negedge clock);
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0 && receiver_idle_on && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
         rsp_tready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("error_diffusion_dither_unit test failed");
         $finish;
      end
   end

   initial begin
      int          phase;
      int          count;
      int          r, a, c0, c1, c2;
      int unsigned w;
      bit          starts_frame;
      width_reg = edd_pkg::WIDTH_RESET;
      clear_error_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes at the reset width, zero alpha and saturating un-premultiply
      push_pixel(0, 0, 0, 255, 1'b1);
      push_pixel(255, 255, 255, 255, 1'b0);
      push_pixel(200, 100, 50, 0, 1'b0);
      push_pixel(1, 1, 1, 1, 1'b0);
      push_pixel(255, 0, 0, 128, 1'b0);
      push_pixel(0, 0, 255, 255, 1'b0);
      wait_idle();

      // short rows in both directions
      write_width(3);
      push_pixel(128, 128, 128, 255, 1'b1);
      push_pixel(100, 100, 100, 200, 1'b0);
      push_pixel(60, 60, 60, 255, 1'b0);
      push_pixel(0, 255, 0, 255, 1'b0);
      push_pixel(128, 128, 128, 255, 1'b0);
      push_pixel(128, 128, 128, 255, 1'b0);
      push_pixel(90, 180, 30, 255, 1'b0);
      wait_idle();

      // widen mid-row, then shrink so the column is clamped to the row end
      write_width(5);
      push_pixel(127, 127, 127, 255, 1'b0);
      push_pixel(129, 129, 129, 255, 1'b0);
      push_pixel(64, 32, 16, 128, 1'b0);
      wait_idle();
      write_width(2);
      push_pixel(200, 200, 200, 255, 1'b0);
      push_pixel(50, 50, 50, 255, 1'b0);
      wait_idle();

      // zero width behaves as one, oversize as the maximum
      write_width(0);
      push_pixel(130, 130, 130, 255, 1'b0);
      push_pixel(120, 120, 120, 255, 1'b0);
      wait_idle();
      write_width(4095);
      push_pixel(140, 70, 200, 255, 1'b1);
      push_pixel(10, 250, 10, 255, 1'b0);
      wait_idle();
      write_width(1);
      push_pixel(255, 255, 255, 0, 1'b1);
      wait_idle();

      phase = 0;
      while (pixels_pushed < TARGET_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70) w = $urandom_range(1, 12);
         else if (r < 88) w = $urandom_range(13, 80);
         else if (r < 92) w = 0;
         else if (r < 96) w = edd_pkg::MAX_WIDTH;
         else w = $urandom_range(edd_pkg::MAX_WIDTH + 1, 4095);
         write_width(w);
         count = (w == 0 || w > 80) ? $urandom_range(10, 30) : $urandom_range(20, 90);
         starts_frame     = ($urandom_range(0, 4) != 0);
         sender_idle_on   = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         @(posedge clock);
         if (phase == 2 || $urandom_range(0, 11) == 0) begin
            // receiver holds off while the sender keeps offering
            sender_idle_on = 1'b0;
            hold_request   = 1'b1;
            if (count < 40) count = 40;
         end
         for (int i = 0; i < count; i++) begin
            a = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(0, 255);
            if (a != 0 && $urandom_range(0, 9) < 8) begin
               c0 = $urandom_range(0, a);
               c1 = $urandom_range(0, a);
               c2 = $urandom_range(0, a);
            end else begin
               c0 = $urandom_range(0, 255);
               c1 = $urandom_range(0, 255);
               c2 = $urandom_range(0, 255);
            end
            push_pixel(c0, c1, c2, a,
                       (i == 0 && starts_frame) || ($urandom_range(0, 63) == 0));
         end
         wait_idle();
         phase++;
      end

      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("error_diffusion_dither_unit test passed");
      end else begin
         $display("error_diffusion_dither_unit test failed");
      end
      $finish;
   end

endmodule
